// ===== rtl/core/lspd_pkg.sv =====
// ----------------------------------------------------------------------------
// lspd_pkg
// Types, register indexes, channel weights and fixed widths shared by the
// line sensor position / PD steering block.
// ----------------------------------------------------------------------------
package lspd_pkg;

  localparam int CHANNELS     = 8;
  localparam int WEIGHT_W     = 10;   // channel weight, signed
  localparam int SUM_W        = 11;   // weight sum, signed, |sum| <= 900
  localparam int COUNT_W      = 4;    // black channel count, 0..8
  localparam int DIVIDEND_W   = 18;   // |sum| * 256
  localparam int DIVISOR_W    = 4;    // count, 1..8
  localparam int FILT_W       = 18;   // filtered error, signed Q.8
  localparam int ERR_W        = 10;   // integer error, signed
  localparam int DERR_W       = 11;   // error difference, signed
  localparam int MUL_A_W      = 18;   // shared multiplier, signed operand A
  localparam int MUL_B_W      = 17;   // shared multiplier, signed operand B
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int ACC_W        = PROD_W + 1;
  localparam int TURN_W       = 21;   // truncated PD value before clamp
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int LOST_TIME_MAX = 60000;
  localparam int LOST_TICK_MAX = 255;
  localparam int ALPHA_ONE     = 256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLACK_LEVEL    = 3'd0,
    REG_REVERSE_ORDER  = 3'd1,
    REG_TURN_NEGATE    = 3'd2,
    REG_GAIN_P         = 3'd3,
    REG_GAIN_D         = 3'd4,
    REG_TURN_LIMIT     = 3'd5,
    REG_FILTER_ALPHA   = 3'd6,
    REG_TICK_PERIOD_MS = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_FM1,
    ST_FM2,
    ST_FADD,
    ST_FILT,
    ST_HOLD,
    ST_PM1,
    ST_PM2,
    ST_PADD,
    ST_TURN,
    ST_CLAMP,
    ST_DONE
  } state_t;

  // Position weight of each logical channel, left to right.
  function automatic logic signed [WEIGHT_W-1:0] chan_weight(input logic [2:0] idx);
    logic signed [WEIGHT_W-1:0] w;
    case (idx)
      3'd0:    w = -10'sd400;
      3'd1:    w = -10'sd280;
      3'd2:    w = -10'sd160;
      3'd3:    w = -10'sd60;
      3'd4:    w = 10'sd60;
      3'd5:    w = 10'sd160;
      3'd6:    w = 10'sd280;
      3'd7:    w = 10'sd400;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/lspd_div.sv =====
// ----------------------------------------------------------------------------
// lspd_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse
// loads the operands; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module lspd_div #(
  parameter int DIVIDEND_W = lspd_pkg::DIVIDEND_W,
  parameter int DIVISOR_W  = lspd_pkg::DIVISOR_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  always_comb begin
    shifted = {rem, quo[DIVIDEND_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= CNT_W'(DIVIDEND_W);
      end else if (cnt != '0) begin
        // the remainder stays below the divisor, so its top bit drops
        rem <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/core/line_sensor_position_pd_steer_top.sv =====
// ----------------------------------------------------------------------------
// line_sensor_position_pd_steer_top
// Line position from an 8-channel digital sensor with PD steering output.
// ----------------------------------------------------------------------------
// One sensor sample in, one result out. A sample with at least one black
// channel waits on the bit-serial divider that averages the channel weights,
// then passes through one shared 18x17 multiplier for the filter and the PD
// terms. A sample with no black channel skips the divider and the filter.
// The block takes one sample at a time; a finished result sits in the output
// register, so the next sample can be taken while it waits.
// Write configuration only while no sample is in progress.
module line_sensor_position_pd_steer_top (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          sensor_bits,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [9:0]                   line_error,
  output logic                                line_valid,
  output logic [7:0]                          logical_mask,
  output logic [7:0]                          physical_mask,
  output logic [3:0]                          black_count,
  output logic [7:0]                          lost_ticks,
  output logic [15:0]                         lost_time_ms,
  output logic signed [1:0]                   last_direction,
  output logic signed [15:0]                  turn_command,
  // configuration
  input  logic                                cfg_we,
  input  logic [lspd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lspd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration registers
  logic        black_level;
  logic        reverse_order;
  logic        turn_negate;
  logic [15:0] gain_p;
  logic [15:0] gain_d;
  logic [14:0] turn_limit;
  logic [8:0]  filter_alpha;
  logic [7:0]  tick_period_ms;

  // control state
  lspd_pkg::state_t state, state_next;
  logic             have_valid;
  logic signed [lspd_pkg::FILT_W-1:0] filtered_error;
  logic signed [lspd_pkg::ERR_W-1:0]  held_error;
  logic signed [lspd_pkg::ERR_W-1:0]  previous_ctrl_error;
  logic [7:0]       lost_tick_count;
  logic [15:0]      lost_time;
  logic signed [1:0] direction_reg;

  // per-sample working registers
  logic [7:0]  pmask;
  logic [7:0]  lmask;
  logic [lspd_pkg::COUNT_W-1:0]      count;
  logic                              sum_neg;
  logic signed [lspd_pkg::FILT_W-1:0] raw;
  logic signed [lspd_pkg::PROD_W-1:0] prod;
  logic signed [lspd_pkg::ACC_W-1:0]  acc;
  logic signed [lspd_pkg::TURN_W-1:0] turn;
  logic signed [lspd_pkg::TURN_W-1:0] turn_clamped;

  // combinational
  logic        in_take;
  logic        out_free;
  logic [7:0]  pmask_in;
  logic [7:0]  lmask_in;
  logic [lspd_pkg::COUNT_W-1:0]      count_c;
  logic signed [lspd_pkg::SUM_W-1:0] sum_c;
  logic signed [lspd_pkg::SUM_W-1:0] sum_abs;
  logic [lspd_pkg::SUM_W-2:0]        sum_mag;
  logic        div_start;
  logic        div_done;
  logic [lspd_pkg::DIVIDEND_W-1:0] div_quo;
  logic [8:0]  alpha_eff;
  logic [8:0]  alpha_rest;
  logic signed [lspd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lspd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [lspd_pkg::PROD_W-1:0] mul_p;
  logic signed [lspd_pkg::DERR_W-1:0] derr;
  logic signed [lspd_pkg::FILT_W-1:0] filt_adj;
  logic signed [lspd_pkg::ACC_W-1:0]  acc_adj;
  logic signed [lspd_pkg::TURN_W-1:0] turn_trunc;
  logic signed [lspd_pkg::TURN_W-1:0] lim;
  logic [16:0] lost_time_sum;
  logic signed [lspd_pkg::FILT_W-1:0] raw_next;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      black_level    <= 1'b1;
      reverse_order  <= 1'b0;
      turn_negate    <= 1'b1;
      gain_p         <= 16'd256;
      gain_d         <= 16'd0;
      turn_limit     <= 15'd32767;
      filter_alpha   <= 9'd256;
      tick_period_ms <= 8'd10;
    end else if (cfg_we) begin
      case (lspd_pkg::reg_index_t'(cfg_index))
        lspd_pkg::REG_BLACK_LEVEL:    black_level    <= cfg_data[0];
        lspd_pkg::REG_REVERSE_ORDER:  reverse_order  <= cfg_data[0];
        lspd_pkg::REG_TURN_NEGATE:    turn_negate    <= cfg_data[0];
        lspd_pkg::REG_GAIN_P:         gain_p         <= cfg_data;
        lspd_pkg::REG_GAIN_D:         gain_d         <= cfg_data;
        lspd_pkg::REG_TURN_LIMIT:     turn_limit     <= cfg_data[14:0];
        lspd_pkg::REG_FILTER_ALPHA:   filter_alpha   <= cfg_data[8:0];
        lspd_pkg::REG_TICK_PERIOD_MS: tick_period_ms <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // masks, count and weight sum
  // --------------------------------------------------------------------------
  always_comb begin
    pmask_in = black_level ? sensor_bits : ~sensor_bits;
    for (int i = 0; i < lspd_pkg::CHANNELS; i++) begin
      lmask_in[i] = reverse_order ? pmask_in[lspd_pkg::CHANNELS-1-i] : pmask_in[i];
    end
  end

  always_comb begin
    count_c = '0;
    sum_c   = '0;
    for (int i = 0; i < lspd_pkg::CHANNELS; i++) begin
      if (lmask[i]) begin
        count_c = count_c + 1'b1;
        sum_c   = sum_c + lspd_pkg::SUM_W'(lspd_pkg::chan_weight(3'(i)));
      end
    end
    sum_abs = (sum_c < 0) ? -sum_c : sum_c;
    sum_mag = sum_abs[lspd_pkg::SUM_W-2:0];
  end

  // --------------------------------------------------------------------------
  // divider for the weighted average
  // --------------------------------------------------------------------------
  // the divider loads straight from the adder chain in the sum cycle
  lspd_div #(
    .DIVIDEND_W (lspd_pkg::DIVIDEND_W),
    .DIVISOR_W  (lspd_pkg::DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_mag, 8'd0}),
    .divisor  (count_c),
    .done     (div_done),
    .quotient (div_quo)
  );

  // --------------------------------------------------------------------------
  // shared multiplier and datapath helpers
  // --------------------------------------------------------------------------
  always_comb begin
    if (!have_valid || filter_alpha > 9'(lspd_pkg::ALPHA_ONE)) begin
      alpha_eff = 9'(lspd_pkg::ALPHA_ONE);
    end else begin
      alpha_eff = filter_alpha;
    end
    alpha_rest = 9'(lspd_pkg::ALPHA_ONE) - alpha_eff;
    derr = lspd_pkg::DERR_W'(held_error) - lspd_pkg::DERR_W'(previous_ctrl_error);

    case (state)
      lspd_pkg::ST_FM1: begin
        mul_a = filtered_error;
        mul_b = $signed({8'd0, alpha_rest});
      end
      lspd_pkg::ST_FM2: begin
        mul_a = raw;
        mul_b = $signed({8'd0, alpha_eff});
      end
      lspd_pkg::ST_PM1: begin
        mul_a = lspd_pkg::MUL_A_W'(held_error);
        mul_b = $signed({1'b0, gain_p});
      end
      lspd_pkg::ST_PM2: begin
        mul_a = lspd_pkg::MUL_A_W'(derr);
        mul_b = $signed({1'b0, gain_d});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;

    // truncate toward zero on divide by 256: bias negatives by 255
    filt_adj   = filtered_error + (filtered_error < 0 ? lspd_pkg::FILT_W'(255) : '0);
    acc_adj    = acc + (acc < 0 ? lspd_pkg::ACC_W'(255) : '0);
    turn_trunc = acc_adj[lspd_pkg::TURN_W+7:8];
    lim        = lspd_pkg::TURN_W'(turn_limit);

    lost_time_sum = {1'b0, lost_time} + 17'(tick_period_ms);

    raw_next = sum_neg ? -lspd_pkg::FILT_W'(div_quo) : lspd_pkg::FILT_W'(div_quo);
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lspd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lspd_pkg::ST_IDLE:  if (in_valid) state_next = lspd_pkg::ST_SUM;
      lspd_pkg::ST_SUM:   state_next = (count_c == '0) ? lspd_pkg::ST_PM1 : lspd_pkg::ST_DIV;
      lspd_pkg::ST_DIV:   if (div_done) state_next = lspd_pkg::ST_FM1;
      lspd_pkg::ST_FM1:   state_next = lspd_pkg::ST_FM2;
      lspd_pkg::ST_FM2:   state_next = lspd_pkg::ST_FADD;
      lspd_pkg::ST_FADD:  state_next = lspd_pkg::ST_FILT;
      lspd_pkg::ST_FILT:  state_next = lspd_pkg::ST_HOLD;
      lspd_pkg::ST_HOLD:  state_next = lspd_pkg::ST_PM1;
      lspd_pkg::ST_PM1:   state_next = lspd_pkg::ST_PM2;
      lspd_pkg::ST_PM2:   state_next = lspd_pkg::ST_PADD;
      lspd_pkg::ST_PADD:  state_next = lspd_pkg::ST_TURN;
      lspd_pkg::ST_TURN:  state_next = lspd_pkg::ST_CLAMP;
      lspd_pkg::ST_CLAMP: state_next = lspd_pkg::ST_DONE;
      lspd_pkg::ST_DONE:  if (out_free) state_next = lspd_pkg::ST_IDLE;
      default:            state_next = lspd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != lspd_pkg::ST_IDLE);
    in_take   = in_valid && !in_stall;
    out_free  = !out_valid || !out_stall;
    div_start = (state == lspd_pkg::ST_SUM) && (count_c != '0);
  end

  // --------------------------------------------------------------------------
  // tracking state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      have_valid          <= 1'b0;
      filtered_error      <= '0;
      held_error          <= '0;
      previous_ctrl_error <= '0;
      lost_tick_count     <= '0;
      lost_time           <= '0;
      direction_reg       <= '0;
    end else begin
      case (state)
        lspd_pkg::ST_SUM: begin
          if (count_c == '0) begin
            if (lost_tick_count != 8'(lspd_pkg::LOST_TICK_MAX)) begin
              lost_tick_count <= lost_tick_count + 1'b1;
            end
            if (lost_time_sum <= 17'(lspd_pkg::LOST_TIME_MAX)) begin
              lost_time <= lost_time_sum[15:0];
            end
          end else begin
            lost_tick_count <= '0;
            lost_time       <= '0;
          end
        end
        lspd_pkg::ST_FILT: begin
          // floor of the Q.8 product sum
          filtered_error <= acc[lspd_pkg::FILT_W+7:8];
          have_valid     <= 1'b1;
        end
        lspd_pkg::ST_HOLD: begin
          held_error    <= filt_adj[lspd_pkg::ERR_W+7:8];
          direction_reg <= (filt_adj < 0) ? -2'sd1 : 2'sd1;
        end
        lspd_pkg::ST_PADD: previous_ctrl_error <= held_error;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // working registers (payload, no reset)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      pmask <= pmask_in;
      lmask <= lmask_in;
    end
    case (state)
      lspd_pkg::ST_SUM: begin
        count   <= count_c;
        sum_neg <= sum_c < 0;
      end
      lspd_pkg::ST_DIV:   if (div_done) raw <= raw_next;
      lspd_pkg::ST_FM1:   prod <= mul_p;
      lspd_pkg::ST_FM2: begin
        acc  <= lspd_pkg::ACC_W'(prod);
        prod <= mul_p;
      end
      lspd_pkg::ST_FADD:  acc <= acc + lspd_pkg::ACC_W'(prod);
      lspd_pkg::ST_PM1:   prod <= mul_p;
      lspd_pkg::ST_PM2: begin
        acc  <= lspd_pkg::ACC_W'(prod);
        prod <= mul_p;
      end
      lspd_pkg::ST_PADD:  acc <= acc + lspd_pkg::ACC_W'(prod);
      lspd_pkg::ST_TURN:  turn <= turn_negate ? -turn_trunc : turn_trunc;
      lspd_pkg::ST_CLAMP: begin
        if (turn > lim) begin
          turn_clamped <= lim;
        end else if (turn < -lim) begin
          turn_clamped <= -lim;
        end else begin
          turn_clamped <= turn;
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lspd_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lspd_pkg::ST_DONE && out_free) begin
      line_error     <= held_error;
      line_valid     <= (count != '0);
      logical_mask   <= lmask;
      physical_mask  <= pmask;
      black_count    <= count;
      lost_ticks     <= lost_tick_count;
      lost_time_ms   <= lost_time;
      last_direction <= direction_reg;
      turn_command   <= turn_clamped[15:0];
    end
  end

endmodule

// ===== dv/line_sensor_position_pd_steer_top_tb.sv =====
// ----------------------------------------------------------------------------
// line_sensor_position_pd_steer_top_tb
// Self-checking bench for the line position / PD steering block. A directed
// table covers reset behavior, field extremes and each register, then random
// sensor patterns (line runs, lost runs, noise) run under changing settings.
// Results are compared field by field with typed rows or a local predictor.
// ----------------------------------------------------------------------------
module line_sensor_position_pd_steer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [9:0]  line_error;
    logic               line_valid;
    logic [7:0]         logical_mask;
    logic [7:0]         physical_mask;
    logic [3:0]         black_count;
    logic [7:0]         lost_ticks;
    logic [15:0]        lost_time_ms;
    logic signed [1:0]  last_direction;
    logic signed [15:0] turn_command;
  } steer_result_t;

  typedef struct packed {
    logic                 is_write;
    logic                 typed;
    lspd_pkg::reg_index_t index;
    logic [15:0]          data;
    logic [7:0]           bits;
    steer_result_t        want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  sensor_bits = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [9:0]  line_error;
  logic        line_valid;
  logic [7:0]  logical_mask;
  logic [7:0]  physical_mask;
  logic [3:0]  black_count;
  logic [7:0]  lost_ticks;
  logic [15:0] lost_time_ms;
  logic signed [1:0]  last_direction;
  logic signed [15:0] turn_command;
  logic        cfg_we = 1'b0;
  logic [lspd_pkg::CFG_INDEX_W-1:0] cfg_index = lspd_pkg::REG_BLACK_LEVEL;
  logic [lspd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of the configuration and state
  logic m_black_level, m_reverse, m_negate;
  int   m_gain_p, m_gain_d, m_limit, m_alpha, m_tick;
  int   filt_q8, held_err, prev_err, lost_cnt, lost_ms, dir_state;
  bit   seen_line;
  int   chan_pos [8] = '{-400, -280, -160, -60, 60, 160, 280, 400};

  steer_result_t results_q[$];
  table_row_t    stim_table[$];
  steer_result_t typed_want, got, want, pred;
  logic          use_typed = 1'b0;
  logic          cur_black = 1'b1;
  int            fail_count = 0;
  int            checked = 0;
  bit            src_idle = 1'b0;
  bit            sink_idle = 1'b0;
  bit            long_hold_req = 1'b0;
  int            hold_cnt = 0;

  line_sensor_position_pd_steer_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sensor_bits    (sensor_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .line_error     (line_error),
    .line_valid     (line_valid),
    .logical_mask   (logical_mask),
    .physical_mask  (physical_mask),
    .black_count    (black_count),
    .lost_ticks     (lost_ticks),
    .lost_time_ms   (lost_time_ms),
    .last_direction (last_direction),
    .turn_command   (turn_command),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("line_sensor_position_pd_steer_top test failed");
    $finish;
  end

  task automatic report_error(input string msg);
    fail_count++;
    if (fail_count <= 50) $display("ERROR t=%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got_v,
                             input logic signed [31:0] want_v);
    if (got_v !== want_v)
      report_error($sformatf("result %0d %s: got %0d, expected %0d",
                             checked, name, got_v, want_v));
  endtask

  // Centroid, filter, lost bookkeeping and PD turn for one sample.
  function automatic steer_result_t predict_steer(input logic [7:0] bits);
    steer_result_t r;
    logic [7:0] pm, lm;
    int cnt, sum, raw, a, ch, err;
    longint acc, pd, turn;
    pm = '0;
    lm = '0;
    cnt = 0;
    sum = 0;
    for (int i = 0; i < 8; i++)
      if (bits[i] == m_black_level) pm[i] = 1'b1;
    for (int i = 0; i < 8; i++) begin
      ch = m_reverse ? 7 - i : i;
      if (pm[ch]) begin
        lm[i] = 1'b1;
        sum += chan_pos[i];
        cnt++;
      end
    end
    if (cnt == 0) begin
      if (lost_cnt < lspd_pkg::LOST_TICK_MAX) lost_cnt++;
      if (lost_ms <= lspd_pkg::LOST_TIME_MAX - m_tick) lost_ms += m_tick;
    end else begin
      raw = (sum * 256) / cnt;
      a = (m_alpha > lspd_pkg::ALPHA_ONE) ? lspd_pkg::ALPHA_ONE : m_alpha;
      if (!seen_line) begin
        filt_q8 = raw;
        seen_line = 1'b1;
      end else begin
        acc = longint'(filt_q8) * (lspd_pkg::ALPHA_ONE - a) + longint'(raw) * a;
        filt_q8 = int'(acc >>> 8);   // floor toward minus infinity
      end
      held_err = filt_q8 / 256;
      dir_state = (held_err >= 0) ? 1 : -1;
      lost_cnt = 0;
      lost_ms = 0;
    end
    err = held_err;
    pd = longint'(err) * m_gain_p + longint'(err - prev_err) * m_gain_d;
    prev_err = err;
    turn = pd / 256;
    if (m_negate) turn = -turn;
    if (turn > m_limit) turn = m_limit;
    if (turn < -m_limit) turn = -m_limit;
    r.line_error     = err[9:0];
    r.line_valid     = (cnt != 0);
    r.logical_mask   = lm;
    r.physical_mask  = pm;
    r.black_count    = cnt[3:0];
    r.lost_ticks     = lost_cnt[7:0];
    r.lost_time_ms   = lost_ms[15:0];
    r.last_direction = dir_state[1:0];
    r.turn_command   = turn[15:0];
    return r;
  endfunction

  // Configuration shadow, result checking and prediction at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      m_black_level = 1'b1;
      m_reverse = 1'b0;
      m_negate = 1'b1;
      m_gain_p = 256;
      m_gain_d = 0;
      m_limit = 32767;
      m_alpha = 256;
      m_tick = 10;
      filt_q8 = 0;
      seen_line = 1'b0;
      held_err = 0;
      prev_err = 0;
      lost_cnt = 0;
      lost_ms = 0;
      dir_state = 0;
      results_q.delete();
    end else begin
      if (cfg_we) begin
        case (lspd_pkg::reg_index_t'(cfg_index))
          lspd_pkg::REG_BLACK_LEVEL:    m_black_level = cfg_data[0];
          lspd_pkg::REG_REVERSE_ORDER:  m_reverse = cfg_data[0];
          lspd_pkg::REG_TURN_NEGATE:    m_negate = cfg_data[0];
          lspd_pkg::REG_GAIN_P:         m_gain_p = int'(cfg_data[15:0]);
          lspd_pkg::REG_GAIN_D:         m_gain_d = int'(cfg_data[15:0]);
          lspd_pkg::REG_TURN_LIMIT:     m_limit = int'(cfg_data[14:0]);
          lspd_pkg::REG_FILTER_ALPHA:   m_alpha = int'(cfg_data[8:0]);
          lspd_pkg::REG_TICK_PERIOD_MS: m_tick = int'(cfg_data[7:0]);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.line_error     = line_error;
        got.line_valid     = line_valid;
        got.logical_mask   = logical_mask;
        got.physical_mask  = physical_mask;
        got.black_count    = black_count;
        got.lost_ticks     = lost_ticks;
        got.lost_time_ms   = lost_time_ms;
        got.last_direction = last_direction;
        got.turn_command   = turn_command;
        if (results_q.size() == 0) begin
          report_error("result transfer with no sample pending");
        end else begin
          want = results_q.pop_front();
          check_field("line_error", 32'(got.line_error), 32'(want.line_error));
          check_field("line_valid", 32'(got.line_valid), 32'(want.line_valid));
          check_field("logical_mask", 32'(got.logical_mask), 32'(want.logical_mask));
          check_field("physical_mask", 32'(got.physical_mask),
                      32'(want.physical_mask));
          check_field("black_count", 32'(got.black_count), 32'(want.black_count));
          check_field("lost_ticks", 32'(got.lost_ticks), 32'(want.lost_ticks));
          check_field("lost_time_ms", 32'(got.lost_time_ms), 32'(want.lost_time_ms));
          check_field("last_direction", 32'(got.last_direction),
                      32'(want.last_direction));
          check_field("turn_command", 32'(got.turn_command), 32'(want.turn_command));
        end
        checked++;
      end
      if (in_valid && !in_stall) begin
        pred = predict_steer(sensor_bits);
        results_q.push_back(use_typed ? typed_want : pred);
      end
    end
  end

  // Result side: short random stall bursts, plus one long hold on request.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cnt = 399;
      out_stall <= 1'b1;
    end else if (sink_idle && $urandom_range(0, 9) == 0) begin
      hold_cnt = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic add_write(input lspd_pkg::reg_index_t idx, input logic [15:0] data);
    table_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.index = idx;
    row.data = data;
    stim_table.push_back(row);
  endtask

  task automatic add_sample(input logic [7:0] bits);
    table_row_t row;
    row = '0;
    row.bits = bits;
    stim_table.push_back(row);
  endtask

  task automatic add_typed(input logic [7:0] bits, input int err, input int valid,
                           input int lm, input int pm, input int cnt, input int ticks,
                           input int ms, input int dir, input int turn);
    table_row_t row;
    row = '0;
    row.bits = bits;
    row.typed = 1'b1;
    row.want.line_error     = err[9:0];
    row.want.line_valid     = valid[0];
    row.want.logical_mask   = lm[7:0];
    row.want.physical_mask  = pm[7:0];
    row.want.black_count    = cnt[3:0];
    row.want.lost_ticks     = ticks[7:0];
    row.want.lost_time_ms   = ms[15:0];
    row.want.last_direction = dir[1:0];
    row.want.turn_command   = turn[15:0];
    stim_table.push_back(row);
  endtask

  task automatic send_sample(input logic [7:0] bits, input logic typed,
                             input steer_result_t expected);
    int gap;
    gap = 0;
    if (src_idle && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    use_typed = typed;
    typed_want = expected;
    in_valid <= 1'b1;
    sensor_bits <= bits;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every pending result has been transferred.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input lspd_pkg::reg_index_t idx, input logic [15:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == lspd_pkg::REG_BLACK_LEVEL) cur_black = data[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_value(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Mostly a narrow run of black channels, some lost samples, some noise.
  function automatic logic [7:0] make_bits(input logic black);
    logic [7:0] line;
    int r, w, pos;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      w = $urandom_range(1, 3);
      pos = $urandom_range(0, 8 - w);
      line = ((8'd1 << w) - 8'd1) << pos;
    end else if (r < 75) begin
      line = 8'h00;
    end else begin
      return 8'($urandom_range(0, 255));
    end
    return black ? line : ~line;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    //        bits   err   vld lmask  pmask  cnt tck  ms  dir  turn
    add_typed(8'h00, 0,    0,  8'h00, 8'h00, 0,  1,  10, 0,   0);
    add_typed(8'h00, 0,    0,  8'h00, 8'h00, 0,  2,  20, 0,   0);
    add_typed(8'h01, -400, 1,  8'h01, 8'h01, 1,  0,  0,  -1,  400);
    add_typed(8'h80, 400,  1,  8'h80, 8'h80, 1,  0,  0,  1,   -400);
    add_typed(8'hFF, 0,    1,  8'hFF, 8'hFF, 8,  0,  0,  1,   0);
    add_sample(8'h18);
    add_sample(8'h03);
    add_sample(8'hC0);
    add_sample(8'h00);
    add_write(lspd_pkg::REG_GAIN_P, 16'hFFFF);
    add_write(lspd_pkg::REG_GAIN_D, 16'hFFFF);
    add_write(lspd_pkg::REG_TURN_NEGATE, 16'h0000);
    add_sample(8'h01);
    add_sample(8'h80);
    add_sample(8'h00);
    add_write(lspd_pkg::REG_TURN_LIMIT, 16'h0000);
    add_sample(8'h07);
    add_write(lspd_pkg::REG_TURN_LIMIT, 16'h7FFF);
    add_write(lspd_pkg::REG_REVERSE_ORDER, 16'h0001);
    add_write(lspd_pkg::REG_BLACK_LEVEL, 16'h0000);
    add_sample(8'hFE);
    add_sample(8'h7F);
    add_sample(8'h00);
    add_sample(8'hFF);
    add_write(lspd_pkg::REG_FILTER_ALPHA, 16'h01FF);   // above one acts as one
    add_sample(8'hFC);
    add_write(lspd_pkg::REG_FILTER_ALPHA, 16'h0000);
    add_sample(8'hF0);
    add_sample(8'h0F);
    add_write(lspd_pkg::REG_FILTER_ALPHA, 16'h0080);
    add_sample(8'hE7);
    add_sample(8'h3F);
    add_write(lspd_pkg::REG_TICK_PERIOD_MS, 16'h0000);
    add_sample(8'hFF);
    add_sample(8'hFF);
    add_write(lspd_pkg::REG_TICK_PERIOD_MS, 16'h00FF);
    add_sample(8'hFF);

    sink_idle = 1'b1;
    for (int k = 0; k < stim_table.size(); k++) begin
      if (stim_table[k].is_write)
        write_reg(stim_table[k].index, stim_table[k].data);
      else
        send_sample(stim_table[k].bits, stim_table[k].typed, stim_table[k].want);
    end

    for (int p = 0; p < 12; p++) begin
      src_idle = (p != 11) && (p % 3 != 1);
      sink_idle = (p != 11) && (p % 4 != 2);
      write_reg(lspd_pkg::REG_BLACK_LEVEL, 16'($urandom_range(0, 1)));
      write_reg(lspd_pkg::REG_REVERSE_ORDER, 16'($urandom_range(0, 1)));
      write_reg(lspd_pkg::REG_TURN_NEGATE, 16'($urandom_range(0, 1)));
      write_reg(lspd_pkg::REG_GAIN_P, 16'(pick_value(0, 65535)));
      write_reg(lspd_pkg::REG_GAIN_D, 16'(pick_value(0, 65535)));
      write_reg(lspd_pkg::REG_TURN_LIMIT, 16'(pick_value(0, 32767)));
      write_reg(lspd_pkg::REG_FILTER_ALPHA, 16'(pick_value(0, 511)));
      write_reg(lspd_pkg::REG_TICK_PERIOD_MS, 16'(pick_value(0, 255)));
      if (p == 2) begin
        // fill the block against a long result hold
        src_idle = 1'b0;
        long_hold_req = 1'b1;
      end
      if (p == 3) begin
        // long lost run: saturate the tick count and the lost time
        write_reg(lspd_pkg::REG_TICK_PERIOD_MS, 16'h00FF);
        for (int k = 0; k < 280; k++)
          send_sample(cur_black ? 8'h00 : 8'hFF, 1'b0, '0);
      end
      for (int k = 0; k < 105; k++) begin
        if (p == 5 && k == 50) settle();
        send_sample(make_bits(cur_black), 1'b0, '0);
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("line_sensor_position_pd_steer_top test passed");
    else
      $display("line_sensor_position_pd_steer_top test failed");
    $finish;
  end

endmodule
